>>> design/pcpg_pkg.sv
// Package: fixed-point constants, types and helpers for the polar curve point generator.
package pcpg_pkg;

   localparam int MAX_STEPS_DEF = 2048;
   localparam int FRAC_BITS_DEF = 16;

   localparam int ATAN_N = 25;

   // Curve kinds
   typedef enum logic [2:0] {
      FUNC_NONE0    = 3'd0,
      FUNC_LIMACON  = 3'd1,
      FUNC_CARDIOID = 3'd2,
      FUNC_ROSE3    = 3'd3,
      FUNC_ROSE4    = 3'd4,
      FUNC_SPIRAL   = 3'd5,
      FUNC_NONE6    = 3'd6,
      FUNC_NONE7    = 3'd7
   } func_type;

   // Register indexes
   localparam logic CSR_SCALE  = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   localparam logic [7:0] SCALE_RESET  = 8'd100;
   localparam logic [7:0] OFFSET_RESET = 8'd50;

   // Q.30 constants
   localparam logic [35:0] Q30_PI    = 36'h0C90FDAA2;
   localparam logic [35:0] Q30_TWOPI = 36'h1921FB544;
   localparam logic [35:0] Q30_HPI   = 36'h06487ED51;
   localparam logic [35:0] Q30_GAIN  = 36'h026DD3B6A;

   function automatic logic [35:0] atan_q30(input int i);
      logic [35:0] t;
      begin
         unique case (i)
            0: t = 36'h3243F6A8;   1: t = 36'h1DAC6705;   2: t = 36'h0FADBAFC;
            3: t = 36'h07F56EA6;   4: t = 36'h03FEAB76;   5: t = 36'h01FFD55B;
            6: t = 36'h00FFFAAA;   7: t = 36'h007FFF55;   8: t = 36'h003FFFEA;
            9: t = 36'h001FFFFD;   10: t = 36'h000FFFFF;  11: t = 36'h0007FFFF;
            12: t = 36'h0003FFFF;  13: t = 36'h0001FFFF;  14: t = 36'h0000FFFF;
            15: t = 36'h00007FFF;  16: t = 36'h00003FFF;  17: t = 36'h00001FFF;
            18: t = 36'h00000FFF;  19: t = 36'h000007FF;  20: t = 36'h000003FF;
            21: t = 36'h000001FF;  22: t = 36'h000000FF;  23: t = 36'h0000007F;
            24: t = 36'h0000003F;
            default: t = 36'h0;
         endcase
         return t;
      end
   endfunction

   // Round a Q.30 constant to Q.F
   function automatic logic [35:0] to_qf(input logic [35:0] c, input int f);
      logic [35:0] s;
      begin
         s = c + (36'd1 << (29 - f));
         return s >> (30 - f);
      end
   endfunction

endpackage

>>> design/pcpg_cordic.sv
// Module: pipelined rotation-mode CORDIC with quadrant fold, one angle per cycle while en is high.
module pcpg_cordic #(
   parameter int FRAC_BITS = pcpg_pkg::FRAC_BITS_DEF,
   parameter int AW        = FRAC_BITS + 16,
   parameter int TW        = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [AW-1:0]         in_ang,
   input  logic [TW-1:0]         in_tag,
   output logic                  out_valid,
   output logic signed [FRAC_BITS+2:0] out_cos,
   output logic signed [FRAC_BITS+2:0] out_sin,
   output logic [TW-1:0]         out_tag
);
   import pcpg_pkg::*;

   localparam int NIT = (FRAC_BITS < ATAN_N) ? FRAC_BITS : ATAN_N;
   localparam int NS  = NIT + 2;
   localparam int VW  = FRAC_BITS + 3;
   localparam int ZW  = FRAC_BITS + 4;
   localparam logic [AW-1:0] TWOPI = AW'(to_qf(Q30_TWOPI, FRAC_BITS));
   localparam logic [AW-1:0] TWOPI2 = TWOPI << 1;
   localparam logic signed [ZW-1:0] PI  = ZW'(to_qf(Q30_PI, FRAC_BITS));
   localparam logic signed [ZW-1:0] HPI = ZW'(to_qf(Q30_HPI, FRAC_BITS));
   localparam logic signed [VW-1:0] GAIN = VW'(to_qf(Q30_GAIN, FRAC_BITS));

   logic               v_ff  [NS+1];
   logic [TW-1:0]      t_ff  [NS+1];
   logic               n_ff  [NS+1];
   logic signed [VW-1:0] x_ff [NS+1];
   logic signed [VW-1:0] y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic [AW-1:0]      r_ff;

   // Stage A: modulo 2pi; in-range angles stay below three turns
   logic [AW-1:0] rem_in;
   always_comb begin
      if (in_ang >= TWOPI2) rem_in = in_ang - TWOPI2;
      else if (in_ang >= TWOPI) rem_in = in_ang - TWOPI;
      else rem_in = in_ang;
   end

   // Stage B: fold into [-pi/2, pi/2]
   logic signed [ZW-1:0] zb_in, zs;
   logic nb_in;
   always_comb begin
      zs = $signed(ZW'(r_ff));
      if (zs > PI) zs = zs - $signed(ZW'(TWOPI));
      nb_in = 1'b0;
      zb_in = zs;
      if (zs > HPI) begin
         zb_in = zs - PI; nb_in = 1'b1;
      end else if (zs < -HPI) begin
         zb_in = zs + PI; nb_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         v_ff[1] <= v_ff[0];
         for (int s = 2; s <= NS; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= rem_in;
         t_ff[0] <= in_tag;
         t_ff[1] <= t_ff[0];
         n_ff[1] <= nb_in;
         x_ff[1] <= GAIN;
         y_ff[1] <= '0;
         z_ff[1] <= zb_in;
         for (int s = 2; s <= NS; s++) begin
            t_ff[s] <= t_ff[s-1];
            n_ff[s] <= n_ff[s-1];
            if (s - 2 < NIT) begin
               if (z_ff[s-1] >= 0) begin
                  x_ff[s] <= x_ff[s-1] - (y_ff[s-1] >>> (s-2));
                  y_ff[s] <= y_ff[s-1] + (x_ff[s-1] >>> (s-2));
                  z_ff[s] <= z_ff[s-1] - ZW'(to_qf(atan_q30(s-2), FRAC_BITS));
               end else begin
                  x_ff[s] <= x_ff[s-1] + (y_ff[s-1] >>> (s-2));
                  y_ff[s] <= y_ff[s-1] - (x_ff[s-1] >>> (s-2));
                  z_ff[s] <= z_ff[s-1] + ZW'(to_qf(atan_q30(s-2), FRAC_BITS));
               end
            end else begin
               x_ff[s] <= n_ff[s-1] ? -x_ff[s-1] : x_ff[s-1];
               y_ff[s] <= n_ff[s-1] ? -y_ff[s-1] : y_ff[s-1];
               z_ff[s] <= z_ff[s-1];
            end
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign out_cos   = x_ff[NS];
   assign out_sin   = y_ff[NS];
   assign out_tag   = t_ff[NS];
endmodule

>>> design/polar_curve_point_generator.sv
// Top level: polar curve vertex generator pipeline.
//  channel | ports              | direction
//  request | req_valid/req_ready| in: func, center, step index
//  result  | rsp_valid/rsp_ready| out: point, last, beyond_end
//  config  | csr_we/idx/wdata   | in: radius_scale, radius_offset
// One vertex per cycle while the output is not stalled. Stages in order:
// one capture stage, FRAC_BITS+12 restoring divider stages for theta,
// FRAC_BITS+3 CORDIC stages, then radius, product and output registers.
// Synchronous active-high reset clears all valid bits. A stalled output
// freezes the whole pipeline and holds req_ready low.
module polar_curve_point_generator #(
   parameter int MAX_STEPS = pcpg_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = pcpg_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [9:0]  req_center_x,
   input  logic [9:0]  req_center_y,
   input  logic [10:0] req_step_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [11:0] rsp_point_x,
   output logic signed [11:0] rsp_point_y,
   output logic        rsp_last,
   output logic        rsp_beyond_end,
   input  logic        csr_we,
   input  logic        csr_idx,
   input  logic [7:0]  csr_wdata
);
   import pcpg_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int KW  = 11;
   localparam int NW  = KW + F;        // theta width
   localparam int AW  = NW + 2;        // 3*theta width
   localparam int VW  = F + 3;
   localparam int SW  = $clog2(MAX_STEPS);
   localparam int TW  = 3 + 10 + 10 + 8 + 8 + NW + 2;

   logic [7:0] a_ff, b_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= SCALE_RESET;
         b_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         if (csr_idx == CSR_SCALE) a_ff <= csr_wdata;
         else b_ff <= csr_wdata;
      end
   end

   logic en;
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Stage 0: kmax, flags, capture
   logic [43:0] kprod;
   logic [SW:0] kmax;
   always_comb begin
      kprod = 44'(a_ff) * 44'(Q30_TWOPI);
      kmax  = (a_ff == 8'd0) ? '0 :
              ((kprod[43:30] > 14'(MAX_STEPS - 1)) ? (SW+1)'(MAX_STEPS - 1)
                                                     : (SW+1)'(kprod[43:30]));
   end

   logic        s0_v_ff, s0_last_ff, s0_beyond_ff;
   logic [2:0]  s0_func_ff;
   logic [9:0]  s0_x_ff, s0_y_ff;
   logic [KW-1:0] s0_k_ff;
   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else if (en) s0_v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s0_func_ff   <= req_func;
         s0_x_ff      <= req_center_x;
         s0_y_ff      <= req_center_y;
         s0_k_ff      <= req_step_index;
         s0_beyond_ff <= (12'(req_step_index) > 12'(kmax));
         s0_last_ff   <= (12'(req_step_index) == 12'(kmax));
      end
   end

   // Divider: theta = (k<<F)/a, one quotient bit per stage
   logic          dv_ff [NW+1];
   logic [NW-1:0] dq_ff [NW+1];
   logic [8:0]    dr_ff [NW+1];
   logic [NW-1:0] dn_ff [NW+1];
   logic [TW-NW-3:0] dt_ff [NW+1];
   logic          dl_ff [NW+1];
   logic          db_ff [NW+1];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NW; s++) dv_ff[s] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= s0_v_ff;
         for (int s = 1; s <= NW; s++) dv_ff[s] <= dv_ff[s-1];
      end
   end
   always_ff @(posedge clock) begin
      logic [9:0] t;
      if (en) begin
         dq_ff[0] <= '0;
         dr_ff[0] <= '0;
         dn_ff[0] <= {s0_k_ff, F'(0)};
         dt_ff[0] <= {s0_func_ff, s0_x_ff, s0_y_ff, a_ff, b_ff};
         dl_ff[0] <= s0_last_ff;
         db_ff[0] <= s0_beyond_ff;
         for (int s = 1; s <= NW; s++) begin
            t = {dr_ff[s-1], dn_ff[s-1][NW-1]};
            dn_ff[s] <= dn_ff[s-1] << 1;
            dt_ff[s] <= dt_ff[s-1];
            dl_ff[s] <= dl_ff[s-1];
            db_ff[s] <= db_ff[s-1];
            if (dt_ff[s-1][15:8] != 8'd0 && t >= {2'b0, dt_ff[s-1][15:8]}) begin
               dr_ff[s] <= 9'(t - {2'b0, dt_ff[s-1][15:8]});
               dq_ff[s] <= {dq_ff[s-1][NW-2:0], 1'b1};
            end else begin
               dr_ff[s] <= t[8:0];
               dq_ff[s] <= {dq_ff[s-1][NW-2:0], 1'b0};
            end
         end
      end
   end

   logic [NW-1:0] th;
   logic [2:0]  dfunc;
   assign th = dq_ff[NW];
   assign dfunc = dt_ff[NW][TW-NW-3 -: 3];

   // Two CORDICs: theta, and m*theta
   logic [AW-1:0] mang;
   always_comb begin
      unique case (func_type'(dfunc))
         FUNC_ROSE3: mang = AW'(th) + AW'({th, 1'b0});
         FUNC_ROSE4: mang = AW'({th, 1'b0});
         default:    mang = AW'(th);
      endcase
   end

   logic c1v, c2v;
   logic signed [VW-1:0] c1c, c1s, c2c, c2s;
   logic [TW-1:0] c1t, c2t;
   pcpg_cordic #(.FRAC_BITS(F), .AW(AW), .TW(TW)) u_c1 (
      .clock, .reset, .en, .in_valid(dv_ff[NW]), .in_ang(AW'(th)),
      .in_tag({dt_ff[NW], th, dl_ff[NW], db_ff[NW]}),
      .out_valid(c1v), .out_cos(c1c), .out_sin(c1s), .out_tag(c1t));
   pcpg_cordic #(.FRAC_BITS(F), .AW(AW), .TW(TW)) u_c2 (
      .clock, .reset, .en, .in_valid(dv_ff[NW]), .in_ang(mang),
      .in_tag({dt_ff[NW], th, dl_ff[NW], db_ff[NW]}),
      .out_valid(c2v), .out_cos(c2c), .out_sin(c2s), .out_tag(c2t));

   // Tag fields used by the radius stage
   logic [2:0] ef; logic [7:0] ea, eb;
   logic [NW-1:0] eth;
   assign ef  = c1t[TW-1 -: 3];
   assign ea  = c1t[TW-24 -: 8];
   assign eb  = c1t[TW-32 -: 8];
   assign eth = c1t[NW+1:2];

   // Stage R: radius in Q.F
   localparam int RW = NW + 10;
   logic signed [RW-1:0] r_in;
   always_comb begin
      unique case (func_type'(ef))
         FUNC_LIMACON:  r_in = RW'($signed({1'b0, ea}) * c1c) +
                               $signed(RW'({eb, F'(0)}));
         FUNC_CARDIOID: r_in = RW'($signed({1'b0, ea}) *
                               ($signed(VW'(1) <<< F) + c1c));
         FUNC_ROSE3, FUNC_ROSE4: r_in = RW'($signed({1'b0, ea}) * c2c);
         FUNC_SPIRAL:   r_in = $signed(RW'((RW'(ea) * RW'(eth)) >> 2));
         default:       r_in = '0;
      endcase
   end
   logic rv_ff;
   logic signed [RW-1:0] r_ff;
   logic signed [VW-1:0] rc_ff, rs_ff;
   logic [TW-1:0] rt_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (en) rv_ff <= c1v;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in; rc_ff <= c1c; rs_ff <= c1s; rt_ff <= c1t;
      end
   end

   // Stage M: products
   localparam int PW = RW + VW;
   logic pv_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic [TW-1:0] pt_ff;
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (en) pv_ff <= rv_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= PW'(r_ff) * PW'(rc_ff);
         py_ff <= PW'(r_ff) * PW'(rs_ff);
         pt_ff <= rt_ff;
      end
   end

   // Stage O: add center, truncate, start point, output register
   logic [2:0] of_; logic [9:0] ox, oy; logic [7:0] oa, ob;
   logic [NW-1:0] oth; logic ol, obe;
   assign {of_, ox, oy, oa, ob, oth, ol, obe} = pt_ff;
   localparam int SUMW = PW + 2;
   logic signed [SUMW-1:0] sx, sy, ax, ay;
   logic signed [11:0] ox_in, oy_in;
   logic [11:0] sp;
   always_comb begin
      sx = $signed(SUMW'({ox, (2*F)'(0)})) + SUMW'(px_ff);
      sy = $signed(SUMW'({oy, (2*F)'(0)})) + SUMW'(py_ff);
      ax = sx < 0 ? -sx : sx;
      ay = sy < 0 ? -sy : sy;
      ox_in = sx < 0 ? -12'(ax >>> (2*F)) : 12'(ax >>> (2*F));
      oy_in = sy < 0 ? -12'(ay >>> (2*F)) : 12'(ay >>> (2*F));
      unique case (func_type'(of_))
         FUNC_LIMACON:           sp = 12'(ox) + 12'(oa) + 12'(ob);
         FUNC_CARDIOID:          sp = 12'(ox) + {3'b0, oa, 1'b0};
         FUNC_ROSE3, FUNC_ROSE4: sp = 12'(ox) + 12'(oa);
         default:                sp = 12'(ox);
      endcase
   end
   logic ov_ff, ol_ff, ob_ff;
   logic signed [11:0] oxr_ff, oyr_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (en) ov_ff <= pv_ff;
   end
   // Theta is zero only for the start point
   always_ff @(posedge clock) begin
      if (en) begin
         ob_ff <= obe;
         ol_ff <= ol & ~obe;
         if (obe) begin
            oxr_ff <= '0; oyr_ff <= '0;
         end else if (oth == '0) begin
            oxr_ff <= sp; oyr_ff <= 12'(oy);
         end else begin
            oxr_ff <= ox_in; oyr_ff <= oy_in;
         end
      end
   end

   assign rsp_valid      = ov_ff;
   assign rsp_point_x    = oxr_ff;
   assign rsp_point_y    = oyr_ff;
   assign rsp_last       = ol_ff;
   assign rsp_beyond_end = ob_ff;

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x))
      else $error("result changed while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_last && rsp_beyond_end))
      else $error("last and beyond_end both set");
   a_beyond_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beyond_end |-> rsp_point_x == 0 && rsp_point_y == 0)
      else $error("beyond_end point not zero");
   a_cordic_align: assert property (@(posedge clock) disable iff (reset)
      c1v |-> c2v && c1t == c2t)
      else $error("CORDIC outputs out of step");
`endif
endmodule
